[design/thpc_pkg.sv]
package thpc_pkg;

   // depth of the datapath from request to result
   localparam int LATENCY = 9;

   // calibration register indexes
   typedef enum logic [2:0] {
      CSR_PRESSURE_SENSITIVITY   = 3'd0,
      CSR_PRESSURE_OFFSET        = 3'd1,
      CSR_SENSITIVITY_TEMP_COEFF = 3'd2,
      CSR_OFFSET_TEMP_COEFF      = 3'd3,
      CSR_REFERENCE_TEMPERATURE  = 3'd4,
      CSR_TEMPERATURE_GAIN       = 3'd5
   } csr_index_type;

   // temperature thresholds in centidegrees
   localparam logic signed [15:0] TEMP_REF       = 16'sd2000;
   localparam logic signed [15:0] TEMP_VERY_COLD = -16'sd1500;

   // second-order offset and sensitivity gains
   localparam int OFF2_LO_GAIN   = 61;
   localparam int SENS2_LO_GAIN  = 29;
   localparam int OFF2_VLO_GAIN  = 17;
   localparam int SENS2_VLO_GAIN = 9;

   // humidity scaling
   localparam int HUM_SCALE     = 12500;
   localparam int HUM_OFFSET    = 600;
   localparam int HUM_MAX       = 10000;
   localparam int HUM_TEMP_GAIN = 18;

   // reciprocal of 100, exact for magnitudes below 2^21
   localparam int DIV100_RECIP = 2684355;
   localparam int DIV100_SHIFT = 28;

   // calibration words
   typedef struct packed {
      logic [15:0] c1;
      logic [15:0] c2;
      logic [15:0] c3;
      logic [15:0] c4;
      logic [15:0] c5;
      logic [15:0] c6;
   } cal_type;

   // first-order temperature results handed to the pressure and humidity paths
   typedef struct packed {
      logic signed [15:0] temp1;
      logic signed [15:0] t2;
      logic signed [35:0] c4dt_sh;
      logic signed [34:0] c3dt_sh;
   } temp_bus_type;

endpackage

[design/thpc_temp.sv]
module thpc_temp (
   input  logic                   clock,
   input  thpc_pkg::cal_type      cal,
   input  logic [23:0]            raw_temperature,
   output thpc_pkg::temp_bus_type temp_bus,
   output logic signed [15:0]     temperature_centideg
);
   import thpc_pkg::*;

   localparam int TOUT_DEPTH = LATENCY - 3;

   logic signed [24:0] dt_in;
   logic signed [24:0] dt_ff;
   logic signed [41:0] dtc6_ff;
   logic signed [41:0] c4dt_ff;
   logic signed [41:0] c3dt_ff;
   logic signed [49:0] sq_full;
   logic [47:0]        sq_ff;
   logic [50:0]        sq5;
   logic [49:0]        sq3;
   logic signed [17:0] dtc6_sh;
   temp_bus_type       bus_in;
   temp_bus_type       bus_ff;
   logic signed [15:0] tout_ff [TOUT_DEPTH];

   // stage 1: difference to reference temperature
   assign dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'b0});

   // stage 2: products of dt
   assign sq_full = dt_ff * dt_ff;

   // stage 3: first-order temperature and second-order term
   always_comb begin
      dtc6_sh        = 18'(dtc6_ff >>> 23);
      bus_in.temp1   = dtc6_sh[15:0] + TEMP_REF;
      sq5            = {1'b0, sq_ff, 2'b0} + {3'b0, sq_ff};
      sq3            = {1'b0, sq_ff, 1'b0} + {2'b0, sq_ff};
      if (bus_in.temp1 >= TEMP_REF) begin
         bus_in.t2 = {3'b0, sq5[50:38]};
      end else begin
         bus_in.t2 = sq3[48:33];
      end
      bus_in.c4dt_sh = 36'(c4dt_ff >>> 6);
      bus_in.c3dt_sh = 35'(c3dt_ff >>> 7);
   end

   always_ff @(posedge clock) begin
      dt_ff   <= dt_in;
      dtc6_ff <= dt_ff * $signed({1'b0, cal.c6});
      c4dt_ff <= dt_ff * $signed({1'b0, cal.c4});
      c3dt_ff <= dt_ff * $signed({1'b0, cal.c3});
      sq_ff   <= sq_full[47:0];
      bus_ff  <= bus_in;
   end

   // stage 4 onward: final temperature, delayed to line up with pressure
   always_ff @(posedge clock) begin
      tout_ff[0] <= bus_ff.temp1 - bus_ff.t2;
      for (int i = 1; i < TOUT_DEPTH; i++) begin
         tout_ff[i] <= tout_ff[i-1];
      end
   end

   assign temp_bus             = bus_ff;
   assign temperature_centideg = tout_ff[TOUT_DEPTH-1];

endmodule

[design/thpc_press.sv]
module thpc_press (
   input  logic                   clock,
   input  thpc_pkg::cal_type      cal,
   input  logic [23:0]            pressure_code,
   input  thpc_pkg::temp_bus_type temp_bus,
   output logic [31:0]            pressure_pascal
);
   import thpc_pkg::*;

   localparam int D1_DEPTH = 6;

   logic [23:0]        d1_ff [D1_DEPTH];
   logic signed [16:0] dlo;
   logic signed [16:0] dvlo;
   logic signed [33:0] lo_sq;
   logic signed [33:0] vlo_sq;
   logic [30:0]        lo_ff;
   logic [29:0]        vlo_ff;
   logic               cold_ff;
   logic               vcold_ff;
   logic [35:0]        c4dt4_ff;
   logic [34:0]        c3dt4_ff;
   logic [35:0]        c4dt5_ff;
   logic [34:0]        c3dt5_ff;
   logic [36:0]        off2_lo_p;
   logic [34:0]        off2_vlo_p;
   logic [35:0]        sens2_lo_p;
   logic [33:0]        sens2_vlo_p;
   logic [34:0]        off2_in;
   logic [33:0]        sens2_in;
   logic [34:0]        off2_ff;
   logic [33:0]        sens2_ff;
   logic [37:0]        off_in;
   logic [37:0]        sens_in;
   logic [37:0]        off_ff;
   logic [37:0]        sens_ff;
   logic [37:0]        off7_ff;
   logic [37:0]        off8_ff;
   logic [41:0]        pp_lo_in;
   logic signed [44:0] pp_hi_in;
   logic [41:0]        pp_lo_ff;
   logic signed [44:0] pp_hi_ff;
   logic [62:0]        prod_in;
   logic [62:0]        prod_ff;
   logic [41:0]        prod_sh;
   logic [42:0]        diff;
   logic [31:0]        pres_in;
   logic [31:0]        pres_ff;

   // raw pressure waits for the sensitivity
   always_ff @(posedge clock) begin
      d1_ff[0] <= pressure_code;
      for (int i = 1; i < D1_DEPTH; i++) begin
         d1_ff[i] <= d1_ff[i-1];
      end
   end

   // stage 4: squares of the low and very-low temperature distances
   always_comb begin
      dlo    = 17'(temp_bus.temp1) - 17'(TEMP_REF);
      dvlo   = 17'(temp_bus.temp1) - 17'(TEMP_VERY_COLD);
      lo_sq  = dlo * dlo;
      vlo_sq = dvlo * dvlo;
   end

   // stage 5: second-order offset and sensitivity
   always_comb begin
      off2_lo_p   = 37'(lo_ff) * 37'(OFF2_LO_GAIN);
      off2_vlo_p  = 35'(vlo_ff) * 35'(OFF2_VLO_GAIN);
      sens2_lo_p  = 36'(lo_ff) * 36'(SENS2_LO_GAIN);
      sens2_vlo_p = 34'(vlo_ff) * 34'(SENS2_VLO_GAIN);
      off2_in     = '0;
      sens2_in    = '0;
      if (cold_ff) begin
         off2_in  = 35'(off2_lo_p >> 4);
         sens2_in = 34'(sens2_lo_p >> 4);
      end
      if (vcold_ff) begin
         off2_in  = off2_in + off2_vlo_p;
         sens2_in = sens2_in + sens2_vlo_p;
      end
   end

   // stage 6: offset and sensitivity, two's complement in 38 bits
   always_comb begin
      off_in  = {5'b0, cal.c2, 17'b0} + {{2{c4dt5_ff[35]}}, c4dt5_ff} - {3'b0, off2_ff};
      sens_in = {6'b0, cal.c1, 16'b0} + {{3{c3dt5_ff[34]}}, c3dt5_ff} - {4'b0, sens2_ff};
   end

   // stage 7: raw pressure times sensitivity as two partial products
   always_comb begin
      pp_lo_in = {18'b0, d1_ff[D1_DEPTH-1]} * {24'b0, sens_ff[17:0]};
      pp_hi_in = $signed({1'b0, d1_ff[D1_DEPTH-1]}) * $signed(sens_ff[37:18]);
   end

   // stage 8: combine partial products
   assign prod_in = {pp_hi_ff, 18'b0} + {21'b0, pp_lo_ff};

   // stage 9: scale, remove offset, scale again
   always_comb begin
      prod_sh = prod_ff[62:21];
      diff    = {prod_sh[41], prod_sh} - {{5{off8_ff[37]}}, off8_ff};
      pres_in = {{4{diff[42]}}, diff[42:15]};
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_sq[30:0];
      vlo_ff   <= vlo_sq[29:0];
      cold_ff  <= temp_bus.temp1 < TEMP_REF;
      vcold_ff <= temp_bus.temp1 < TEMP_VERY_COLD;
      c4dt4_ff <= temp_bus.c4dt_sh;
      c3dt4_ff <= temp_bus.c3dt_sh;
      c4dt5_ff <= c4dt4_ff;
      c3dt5_ff <= c3dt4_ff;
      off2_ff  <= off2_in;
      sens2_ff <= sens2_in;
      off_ff   <= off_in;
      sens_ff  <= sens_in;
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      off7_ff  <= off_ff;
      prod_ff  <= prod_in;
      off8_ff  <= off7_ff;
      pres_ff  <= pres_in;
   end

   assign pressure_pascal = pres_ff;

endmodule

[design/thpc_hum.sv]
module thpc_hum (
   input  logic                   clock,
   input  logic [15:0]            humidity_code,
   input  thpc_pkg::temp_bus_type temp_bus,
   output logic [15:0]            humidity_centipercent
);
   import thpc_pkg::*;

   localparam int HUM_DEPTH = LATENCY - 5;

   logic [29:0] rhp_ff;
   logic [13:0] rhs;
   logic [13:0] rh_in;
   logic [13:0] rh2_ff;
   logic [13:0] rh3_ff;
   logic [13:0] rh4_ff;
   logic [13:0] rh5_ff;
   logic [17:0] h;
   logic [22:0] h18;
   logic [22:0] hneg18;
   logic [20:0] hmag_in;
   logic [20:0] hmag_ff;
   logic        hneg_ff;
   logic        hneg5_ff;
   logic [42:0] qp_ff;
   logic [13:0] q;
   logic [15:0] hum_in;
   logic [15:0] hum_ff [HUM_DEPTH];

   // stage 2: scaled reading, clamped to 0..10000
   always_comb begin
      rhs = rhp_ff[29:16];
      if (rhs < 14'(HUM_OFFSET)) begin
         rh_in = '0;
      end else if (rhs > 14'(HUM_OFFSET + HUM_MAX)) begin
         rh_in = 14'(HUM_MAX);
      end else begin
         rh_in = rhs - 14'(HUM_OFFSET);
      end
   end

   // stage 4: temperature correction numerator as sign and magnitude
   always_comb begin
      h       = 18'(TEMP_REF) - {{2{temp_bus.temp1[15]}}, temp_bus.temp1}
                + {{2{temp_bus.t2[15]}}, temp_bus.t2};
      h18     = {{5{h[17]}}, h} * 23'(HUM_TEMP_GAIN);
      hneg18  = -h18;
      hmag_in = h18[22] ? hneg18[20:0] : h18[20:0];
   end

   // stage 6: quotient truncated toward zero, applied to humidity
   always_comb begin
      q = 14'(qp_ff >> DIV100_SHIFT);
      if (hneg5_ff) begin
         hum_in = {2'b0, rh5_ff} + {2'b0, q};
      end else begin
         hum_in = {2'b0, rh5_ff} - {2'b0, q};
      end
   end

   always_ff @(posedge clock) begin
      rhp_ff   <= {14'b0, humidity_code} * 30'(HUM_SCALE);
      rh2_ff   <= rh_in;
      rh3_ff   <= rh2_ff;
      rh4_ff   <= rh3_ff;
      hmag_ff  <= hmag_in;
      hneg_ff  <= h18[22];
      qp_ff    <= {22'b0, hmag_ff} * {21'b0, 22'(DIV100_RECIP)};
      rh5_ff   <= rh4_ff;
      hneg5_ff <= hneg_ff;
   end

   // result delayed to line up with pressure
   always_ff @(posedge clock) begin
      hum_ff[0] <= hum_in;
      for (int i = 1; i < HUM_DEPTH; i++) begin
         hum_ff[i] <= hum_ff[i-1];
      end
   end

   assign humidity_centipercent = hum_ff[HUM_DEPTH-1];

endmodule

[design/pressure_temp_humidity_compensation_unit.sv]
// rsp_valid is the last bit of the valid pipeline, which runs alongside the datapath stages
// throughput: one request per cycle, busy stays low; the slowest stage is one
//   multiplier of at most 25 by 25 bits
// reset: clears the valid pipeline and the six calibration registers
// results are presented for one cycle only; the receiver cannot stall
module pressure_temp_humidity_compensation_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [23:0]        req_raw_temperature,
   input  logic [23:0]        req_pressure_code,
   input  logic [15:0]        req_humidity_code,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_temperature_centideg,
   output logic [31:0]        rsp_pressure_pascal,
   output logic [15:0]        rsp_humidity_centipercent,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import thpc_pkg::*;

   cal_type            cal_in;
   cal_type            cal_ff;
   logic [LATENCY-1:0] valid_in;
   logic [LATENCY-1:0] valid_ff;
   temp_bus_type       temp_bus;

   // never holds off a request
   assign busy = 1'b0;

   // calibration register writes
   always_comb begin
      cal_in = cal_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PRESSURE_SENSITIVITY:   cal_in.c1 = csr_data;
            CSR_PRESSURE_OFFSET:        cal_in.c2 = csr_data;
            CSR_SENSITIVITY_TEMP_COEFF: cal_in.c3 = csr_data;
            CSR_OFFSET_TEMP_COEFF:      cal_in.c4 = csr_data;
            CSR_REFERENCE_TEMPERATURE:  cal_in.c5 = csr_data;
            CSR_TEMPERATURE_GAIN:       cal_in.c6 = csr_data;
            default: begin
            end
         endcase
      end
   end

   // valid bits travel alongside the datapath stages
   assign valid_in = {valid_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff   <= '0;
         valid_ff <= '0;
      end else begin
         cal_ff   <= cal_in;
         valid_ff <= valid_in;
      end
   end

   thpc_temp u_temp (
      .clock                (clock),
      .cal                  (cal_ff),
      .raw_temperature      (req_raw_temperature),
      .temp_bus             (temp_bus),
      .temperature_centideg (rsp_temperature_centideg)
   );

   thpc_press u_press (
      .clock           (clock),
      .cal             (cal_ff),
      .pressure_code   (req_pressure_code),
      .temp_bus        (temp_bus),
      .pressure_pascal (rsp_pressure_pascal)
   );

   thpc_hum u_hum (
      .clock                 (clock),
      .humidity_code         (req_humidity_code),
      .temp_bus              (temp_bus),
      .humidity_centipercent (rsp_humidity_centipercent)
   );

   assign rsp_valid = valid_ff[LATENCY-1];

endmodule

[tb/pressure_temp_humidity_compensation_unit_tb.sv]
module pressure_temp_humidity_compensation_unit_tb;

   import thpc_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 60;
   localparam int DIRECTED_ROWS   = 16;

   // register indexes past the calibration bank, writes there are dropped
   localparam logic [2:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic [23:0] raw_temperature;
      logic [23:0] pressure_code;
      logic [15:0] humidity_code;
   } raw_sample_type;

   typedef struct packed {
      logic signed [15:0] temperature_centideg;
      logic [31:0]        pressure_pascal;
      logic [15:0]        humidity_centipercent;
   } compensated_reading_type;

   // directed stimulus, literal expectations only where they are obvious
   typedef struct packed {
      bit                 typical_cal;
      logic [23:0]        raw_temperature;
      logic [23:0]        pressure_code;
      logic [15:0]        humidity_code;
      bit                 literal;
      logic signed [15:0] want_temperature;
      logic [31:0]        want_pressure;
      logic [15:0]        want_humidity;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [23:0]        req_raw_temperature = '0;
   logic [23:0]        req_pressure_code = '0;
   logic [15:0]        req_humidity_code = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_temperature_centideg;
   logic [31:0]        rsp_pressure_pascal;
   logic [15:0]        rsp_humidity_centipercent;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   cal_type                 cal_words = '0;
   compensated_reading_type expected_readings [$];
   compensated_reading_type literal_reading;
   compensated_reading_type accepted_reading;
   compensated_reading_type oldest_reading;
   directed_row_type        directed_table [DIRECTED_ROWS];
   bit                      literal_pending = 1'b0;
   bit                      burst_mode = 1'b0;
   int unsigned             requests_accepted = 0;
   int unsigned             results_checked = 0;
   int unsigned             mismatch_count = 0;
   int unsigned             settings_loaded = 0;
   int unsigned             cycle_count = 0;

   pressure_temp_humidity_compensation_unit i_dut (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_raw_temperature       (req_raw_temperature),
      .req_pressure_code         (req_pressure_code),
      .req_humidity_code         (req_humidity_code),
      .rsp_valid                 (rsp_valid),
      .rsp_temperature_centideg  (rsp_temperature_centideg),
      .rsp_pressure_pascal       (rsp_pressure_pascal),
      .rsp_humidity_centipercent (rsp_humidity_centipercent),
      .csr_write                 (csr_write),
      .csr_index                 (csr_index),
      .csr_data                  (csr_data)
   );

   always #6 clock = ~clock;

   // second-order compensation, all intermediates held in 64 bits
   function automatic compensated_reading_type compensate_sample(raw_sample_type s,
                                                                 cal_type cal);
      longint d2, d1, d3, dt, temp1, t2, off2, sens2, off, sens, pres, rh, lo, vlo;
      compensated_reading_type r;
      d2 = longint'(s.raw_temperature);
      d1 = longint'(s.pressure_code);
      d3 = longint'(s.humidity_code);
      dt = d2 - longint'(cal.c5) * 256;
      temp1 = shortint'(longint'(TEMP_REF) + ((dt * longint'(cal.c6)) >>> 23));
      off2 = 0;
      sens2 = 0;
      if (temp1 >= longint'(TEMP_REF)) begin
         t2 = shortint'((5 * dt * dt) >>> 38);
      end else begin
         lo = (temp1 - longint'(TEMP_REF)) * (temp1 - longint'(TEMP_REF));
         t2 = shortint'((3 * dt * dt) >>> 33);
         off2 = (OFF2_LO_GAIN * lo) >>> 4;
         sens2 = (SENS2_LO_GAIN * lo) >>> 4;
         // very cold adds a second quadratic term
         if (temp1 < longint'(TEMP_VERY_COLD)) begin
            vlo = (temp1 - longint'(TEMP_VERY_COLD)) * (temp1 - longint'(TEMP_VERY_COLD));
            off2 = off2 + OFF2_VLO_GAIN * vlo;
            sens2 = sens2 + SENS2_VLO_GAIN * vlo;
         end
      end
      off = longint'(cal.c2) * 131072 + ((longint'(cal.c4) * dt) >>> 6) - off2;
      sens = longint'(cal.c1) * 65536 + ((longint'(cal.c3) * dt) >>> 7) - sens2;
      pres = (((d1 * sens) >>> 21) - off) >>> 15;
      // humidity: clamp first, then temperature term with truncating divide
      rh = ((HUM_SCALE * d3) >>> 16) - HUM_OFFSET;
      if (rh > HUM_MAX) begin
         rh = HUM_MAX;
      end else if (rh < 0) begin
         rh = 0;
      end
      rh = rh - (longint'(TEMP_REF) - temp1 + t2) * HUM_TEMP_GAIN / 100;
      r.temperature_centideg = 16'(temp1 - t2);
      r.pressure_pascal = 32'(pres);
      r.humidity_centipercent = 16'(rh);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // request acceptance and result checking
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            accepted_reading = literal_pending ? literal_reading :
               compensate_sample({req_raw_temperature, req_pressure_code, req_humidity_code},
                                 cal_words);
            expected_readings.push_back(accepted_reading);
            requests_accepted++;
         end
         if (rsp_valid) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: t=%0d p=%0d h=%0d",
                  rsp_temperature_centideg, rsp_pressure_pascal, rsp_humidity_centipercent));
            end else begin
               oldest_reading = expected_readings.pop_front();
               if (rsp_temperature_centideg !== oldest_reading.temperature_centideg) begin
                  report_mismatch($sformatf("result %0d temperature got %0d want %0d",
                     results_checked, rsp_temperature_centideg,
                     oldest_reading.temperature_centideg));
               end
               if (rsp_pressure_pascal !== oldest_reading.pressure_pascal) begin
                  report_mismatch($sformatf("result %0d pressure got %0d want %0d",
                     results_checked, rsp_pressure_pascal, oldest_reading.pressure_pascal));
               end
               if (rsp_humidity_centipercent !== oldest_reading.humidity_centipercent) begin
                  report_mismatch($sformatf("result %0d humidity got %0d want %0d",
                     results_checked, rsp_humidity_centipercent,
                     oldest_reading.humidity_centipercent));
               end
            end
            results_checked++;
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("pressure_temp_humidity_compensation_unit regression: fail");
      $finish;
   end

   // one register write, the predictor copy follows the bank
   task automatic write_cal_word(input logic [2:0] index, input logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         CSR_PRESSURE_SENSITIVITY:   cal_words.c1 = data;
         CSR_PRESSURE_OFFSET:        cal_words.c2 = data;
         CSR_SENSITIVITY_TEMP_COEFF: cal_words.c3 = data;
         CSR_OFFSET_TEMP_COEFF:      cal_words.c4 = data;
         CSR_REFERENCE_TEMPERATURE:  cal_words.c5 = data;
         CSR_TEMPERATURE_GAIN:       cal_words.c6 = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_calibration(input cal_type cal);
      write_cal_word(CSR_PRESSURE_SENSITIVITY, cal.c1);
      write_cal_word(CSR_PRESSURE_OFFSET, cal.c2);
      write_cal_word(CSR_SENSITIVITY_TEMP_COEFF, cal.c3);
      write_cal_word(CSR_OFFSET_TEMP_COEFF, cal.c4);
      write_cal_word(CSR_REFERENCE_TEMPERATURE, cal.c5);
      write_cal_word(CSR_TEMPERATURE_GAIN, cal.c6);
      settings_loaded++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_mode || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   // drive one request at the falling edge and hold it until taken
   task automatic send_request(input raw_sample_type s, input bit literal,
                               input compensated_reading_type lit);
      int gap;
      int unsigned seen;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_raw_temperature <= s.raw_temperature;
      req_pressure_code <= s.pressure_code;
      req_humidity_code <= s.humidity_code;
      literal_pending = literal;
      literal_reading = lit;
      seen = requests_accepted;
      do @(negedge clock); while (requests_accepted == seen);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] random_cal_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly temperatures around the reference point, some full-range noise
   function automatic raw_sample_type random_sample(cal_type cal);
      raw_sample_type s;
      longint centre, span, v;
      case ($urandom_range(0, 7))
         0, 1: s.raw_temperature = 24'($urandom);
         2: s.raw_temperature = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         default: begin
            centre = longint'(cal.c5) * 256;
            span = longint'(1) << $urandom_range(0, 23);
            v = centre - span + longint'($urandom_range(0, 32'(2 * span)));
            if (v < 0) v = 0;
            if (v > 24'hFFFFFF) v = 24'hFFFFFF;
            s.raw_temperature = 24'(v);
         end
      endcase
      case ($urandom_range(0, 7))
         0: s.pressure_code = 24'h000000;
         1: s.pressure_code = 24'hFFFFFF;
         default: s.pressure_code = 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: s.humidity_code = 16'h0000;
         1: s.humidity_code = 16'hFFFF;
         2: s.humidity_code = 16'(3140 + $urandom_range(0, 12));
         3: s.humidity_code = 16'(55568 + $urandom_range(0, 12));
         default: s.humidity_code = 16'($urandom);
      endcase
      return s;
   endfunction

   initial begin
      cal_type                 phase_cal;
      directed_row_type        row;
      compensated_reading_type lit;
      bit                      typical_loaded;

      // first rows run on the all-zero bank left by reset
      directed_table = '{
         '{1'b0, 24'h000000, 24'h000000, 16'h0000, 1'b1,  16'sd2000, 32'd0, 16'd0},
         '{1'b0, 24'h000000, 24'hFFFFFF, 16'hFFFF, 1'b1,  16'sd2000, 32'd0, 16'd10000},
         '{1'b0, 24'hFFFFFF, 24'h000000, 16'h0000, 1'b1, -16'sd3119, 32'd0, 16'd64615},
         '{1'b0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, -16'sd3119, 32'd0, 16'd9079},
         '{1'b0, 24'h800000, 24'h000000, 16'h0000, 1'b1,  16'sd720,  32'd0, 16'd65306},
         '{1'b0, 24'h000000, 24'h000000, 16'd3146, 1'b1,  16'sd2000, 32'd0, 16'd0},
         '{1'b0, 24'h000000, 24'h000000, 16'd55574, 1'b1, 16'sd2000, 32'd0, 16'd9999},
         '{1'b0, 24'h000000, 24'h000000, 16'd55575, 1'b1, 16'sd2000, 32'd0, 16'd10000},
         '{1'b1, 24'd8077568, 24'd6465444, 16'd31000, 1'b0, 16'sd0, 32'd0, 16'd0},
         '{1'b1, 24'd8077567, 24'd6465444, 16'd31000, 1'b0, 16'sd0, 32'd0, 16'd0},
         '{1'b1, 24'd0,       24'd6465444, 16'd31000, 1'b0, 16'sd0, 32'd0, 16'd0},
         '{1'b1, 24'd7035068, 24'd6465444, 16'd20000, 1'b0, 16'sd0, 32'd0, 16'd0},
         '{1'b1, 24'hFFFFFF,  24'hFFFFFF,  16'hFFFF,  1'b0, 16'sd0, 32'd0, 16'd0},
         '{1'b1, 24'hFFFFFF,  24'h000000,  16'h0000,  1'b0, 16'sd0, 32'd0, 16'd0},
         '{1'b1, 24'd8400000, 24'h000000,  16'hFFFF,  1'b0, 16'sd0, 32'd0, 16'd0},
         '{1'b1, 24'd5000000, 24'hFFFFFF,  16'd3146,  1'b0, 16'sd0, 32'd0, 16'd0}
      };
      typical_loaded = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_table[i]) begin
         row = directed_table[i];
         if (row.typical_cal && !typical_loaded) begin
            wait_drained();
            load_calibration('{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553,
                               16'd28165});
            // out-of-range indexes must leave the bank alone
            write_cal_word(CSR_SPARE_LOW, 16'hFFFF);
            write_cal_word(CSR_SPARE_HIGH, 16'h1234);
            typical_loaded = 1'b1;
         end
         lit.temperature_centideg = row.want_temperature;
         lit.pressure_pascal = row.want_pressure;
         lit.humidity_centipercent = row.want_humidity;
         send_request({row.raw_temperature, row.pressure_code, row.humidity_code},
                      row.literal, lit);
      end

      // random part, one calibration setting per phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: phase_cal = '1;
            1: phase_cal = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553,
                             16'd28165};
            2: phase_cal = '0;
            default: phase_cal = '{random_cal_word(), random_cal_word(), random_cal_word(),
                                   random_cal_word(), random_cal_word(), random_cal_word()};
         endcase
         load_calibration(phase_cal);
         if (phase % 2 == 1) begin
            write_cal_word(CSR_SPARE_LOW, 16'($urandom));
            write_cal_word(CSR_SPARE_HIGH, 16'($urandom));
         end
         burst_mode = (phase == 2 || phase == 5);
         repeat (PHASE_REQUESTS) send_request(random_sample(cal_words), 1'b0, '0);
      end

      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);

      $display("ran %0d requests (%0d directed) over %0d calibration settings",
               requests_accepted, DIRECTED_ROWS, settings_loaded);
      $display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("pressure_temp_humidity_compensation_unit regression: pass");
      end else begin
         $display("pressure_temp_humidity_compensation_unit regression: fail");
      end
      $finish;
   end

endmodule
